### rtl/core/assert_macros.svh
// assertion macros shared by sfe_framer and sfe_burst_buf
// relies on a clock named clk and an active-low reset named rst_n in the user
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// expression must hold at every clock edge out of reset
`define SFE_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// consequent must hold in the same cycle as the antecedent
`define SFE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// consequent must hold in the cycle after the antecedent
`define SFE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SFE_ASSERT_ALWAYS(lbl, expr, msg)
`define SFE_ASSERT_IMPL(lbl, ante, cons, msg)
`define SFE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### rtl/core/sfe_pkg.sv
// shared types and constants of the serial frame encapsulator
// no dependencies
package sfe_pkg;

  localparam int unsigned MAX_BURST = 7;
  localparam int unsigned BURST_CNT_W = $clog2(MAX_BURST + 1);

  localparam logic [7:0] FIXED_START = 8'h10;
  localparam logic [7:0] HDR_SYNC    = 8'hAA;
  localparam logic [7:0] TRAILER     = 8'h55;
  localparam logic [8:0] FIXED_LEN_SHORT = 9'd5;
  localparam logic [8:0] FIXED_LEN_LONG  = 9'd6;
  localparam logic [8:0] VAR_LEN_OFFSET  = 9'd6;
  localparam logic [8:0] MAX_FRAME_LEN   = 9'd261;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_PORT_NUMBER   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_ADDRESS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 2'd2;
  localparam logic [15:0] TIMEOUT_RESET = 16'd5000;

  typedef struct packed {
    logic       op;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last;
    logic       abort;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  port_number;
    logic        long_address;
    logic [15:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic [BURST_CNT_W-1:0]          count;
    out_item_t [MAX_BURST-1:0]       slot;
  } burst_t;

  function automatic out_item_t mk_item(input logic [7:0] b, input logic lst,
                                        input logic ab);
    out_item_t r;
    r.tx_byte = b;
    r.last    = lst;
    r.abort   = ab;
    return r;
  endfunction

endpackage

### rtl/core/sfe_framer.sv
// frame tracking state and per-item burst generation
// depends on sfe_pkg and assert_macros.svh
`include "assert_macros.svh"

module sfe_framer (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  sfe_pkg::in_item_t item,
  input  sfe_pkg::cfg_t     cfg,
  output sfe_pkg::burst_t   burst
);

  logic [8:0]  byte_count_r, byte_count_nxt;
  logic [8:0]  total_r, total_nxt;
  logic [7:0]  held0_r, held0_nxt;
  logic [7:0]  held1_r, held1_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [15:0] elapsed_r, elapsed_nxt;
  logic        fixed_r, fixed_nxt;

  logic [15:0] elapsed_inc;
  logic [8:0]  count_inc;
  logic [7:0]  sum_add;
  logic [7:0]  min_len;
  logic [8:0]  var_total;
  logic [8:0]  fix_total;
  logic [7:0]  b;

  always_comb begin
    b           = item.rx_byte;
    elapsed_inc = (elapsed_r == 16'hFFFF) ? elapsed_r : elapsed_r + 16'd1;
    count_inc   = byte_count_r + 9'd1;
    sum_add     = sum_r + b;
    min_len     = (held1_r < b) ? held1_r : b;
    var_total   = {1'b0, min_len} + sfe_pkg::VAR_LEN_OFFSET;
    fix_total   = cfg.long_address ? sfe_pkg::FIXED_LEN_LONG : sfe_pkg::FIXED_LEN_SHORT;

    byte_count_nxt = byte_count_r;
    total_nxt      = total_r;
    held0_nxt      = held0_r;
    held1_nxt      = held1_r;
    sum_nxt        = sum_r;
    elapsed_nxt    = elapsed_r;
    fixed_nxt      = fixed_r;
    burst          = '0;

    if (item.op == sfe_pkg::OP_TICK) begin
      if (byte_count_r != 9'd0) begin
        elapsed_nxt = elapsed_inc;
        if (elapsed_inc >= cfg.timeout_ticks) begin
          burst.slot[0] = sfe_pkg::mk_item(8'h00, 1'b1, 1'b1);
          burst.count   = 3'd1;
          byte_count_nxt = '0;
          total_nxt      = '0;
          held0_nxt      = '0;
          held1_nxt      = '0;
          sum_nxt        = '0;
          elapsed_nxt    = '0;
          fixed_nxt      = 1'b0;
        end
      end
    end else if (byte_count_r == 9'd0) begin
      elapsed_nxt    = '0;
      byte_count_nxt = 9'd1;
      if (b == sfe_pkg::FIXED_START) begin
        // fixed frame: length known from the first byte
        fixed_nxt     = 1'b1;
        total_nxt     = fix_total;
        burst.slot[0] = sfe_pkg::mk_item(sfe_pkg::HDR_SYNC, 1'b0, 1'b0);
        burst.slot[1] = sfe_pkg::mk_item(fix_total[7:0], 1'b0, 1'b0);
        burst.slot[2] = sfe_pkg::mk_item({7'd0, fix_total[8]}, 1'b0, 1'b0);
        burst.slot[3] = sfe_pkg::mk_item(cfg.port_number, 1'b0, 1'b0);
        burst.slot[4] = sfe_pkg::mk_item(b, 1'b0, 1'b0);
        burst.count   = 3'd5;
        sum_nxt       = fix_total[7:0] + {7'd0, fix_total[8]} + cfg.port_number + b;
      end else begin
        fixed_nxt = 1'b0;
        held0_nxt = b;
      end
    end else if (!fixed_r && byte_count_r == 9'd1) begin
      held1_nxt      = b;
      byte_count_nxt = 9'd2;
    end else if (!fixed_r && byte_count_r == 9'd2) begin
      // variable frame: length known at the third byte, flush the held pair
      total_nxt      = var_total;
      byte_count_nxt = 9'd3;
      burst.slot[0]  = sfe_pkg::mk_item(sfe_pkg::HDR_SYNC, 1'b0, 1'b0);
      burst.slot[1]  = sfe_pkg::mk_item(var_total[7:0], 1'b0, 1'b0);
      burst.slot[2]  = sfe_pkg::mk_item({7'd0, var_total[8]}, 1'b0, 1'b0);
      burst.slot[3]  = sfe_pkg::mk_item(cfg.port_number, 1'b0, 1'b0);
      burst.slot[4]  = sfe_pkg::mk_item(held0_r, 1'b0, 1'b0);
      burst.slot[5]  = sfe_pkg::mk_item(held1_r, 1'b0, 1'b0);
      burst.slot[6]  = sfe_pkg::mk_item(b, 1'b0, 1'b0);
      burst.count    = 3'd7;
      sum_nxt        = var_total[7:0] + {7'd0, var_total[8]} + cfg.port_number
                       + held0_r + held1_r + b;
    end else begin
      burst.slot[0] = sfe_pkg::mk_item(b, 1'b0, 1'b0);
      if (count_inc >= total_r) begin
        burst.slot[1]  = sfe_pkg::mk_item(sum_add, 1'b0, 1'b0);
        burst.slot[2]  = sfe_pkg::mk_item(sfe_pkg::TRAILER, 1'b1, 1'b0);
        burst.count    = 3'd3;
        byte_count_nxt = '0;
        total_nxt      = '0;
        held0_nxt      = '0;
        held1_nxt      = '0;
        sum_nxt        = '0;
        elapsed_nxt    = '0;
        fixed_nxt      = 1'b0;
      end else begin
        burst.count    = 3'd1;
        byte_count_nxt = count_inc;
        sum_nxt        = sum_add;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      total_r      <= '0;
      held0_r      <= '0;
      held1_r      <= '0;
      sum_r        <= '0;
      elapsed_r    <= '0;
      fixed_r      <= 1'b0;
    end else if (accept) begin
      byte_count_r <= byte_count_nxt;
      total_r      <= total_nxt;
      held0_r      <= held0_nxt;
      held1_r      <= held1_nxt;
      sum_r        <= sum_nxt;
      elapsed_r    <= elapsed_nxt;
      fixed_r      <= fixed_nxt;
    end
  end

  `SFE_ASSERT_IMPL(a_idle_clean, byte_count_r == 9'd0, sum_r == 8'd0 && !fixed_r && elapsed_r == 16'd0, "idle state not clean")
  `SFE_ASSERT_IMPL(a_fixed_len, fixed_r, total_r == sfe_pkg::FIXED_LEN_SHORT || total_r == sfe_pkg::FIXED_LEN_LONG, "fixed frame length out of set")
  `SFE_ASSERT_ALWAYS(a_len_range, total_r <= sfe_pkg::MAX_FRAME_LEN, "frame length too large")

endmodule

### rtl/core/sfe_burst_buf.sv
// result register holding one item's burst and shifting it out byte by byte
// depends on sfe_pkg and assert_macros.svh
`include "assert_macros.svh"

module sfe_burst_buf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  sfe_pkg::burst_t     burst,
  output logic                free,
  output logic                out_valid,
  input  logic                out_stall,
  output sfe_pkg::out_item_t  out_data
);

  logic [sfe_pkg::BURST_CNT_W-1:0]             count_r, count_nxt;
  sfe_pkg::out_item_t [sfe_pkg::MAX_BURST-1:0] slot_r, slot_nxt;
  logic take;

  assign out_valid = (count_r != '0);
  assign out_data  = slot_r[0];
  assign take      = out_valid && !out_stall;
  // room for the next burst when empty or once the final byte leaves
  assign free      = (count_r == '0) || (count_r == 3'd1 && take);

  always_comb begin
    count_nxt = count_r;
    slot_nxt  = slot_r;
    if (load) begin
      count_nxt = burst.count;
      slot_nxt  = burst.slot;
    end else if (take) begin
      count_nxt = count_r - 3'd1;
      for (int i = 0; i < sfe_pkg::MAX_BURST - 1; i++) begin
        slot_nxt[i] = slot_r[i+1];
      end
      slot_nxt[sfe_pkg::MAX_BURST-1] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
  end

  `SFE_ASSERT_ALWAYS(a_count_max, count_r <= 3'd7, "burst count overflow")
  `SFE_ASSERT_NEXT(a_drain, take && !load, count_r == $past(count_r) - 3'd1, "burst did not drain by one")

endmodule

### rtl/core/serial_frame_encapsulator_unit.sv
// top level of the serial frame encapsulator: config registers, framer, burst buffer
// depends on sfe_pkg, sfe_framer, sfe_burst_buf
//
//  channel | ports                          | moves
//  --------+--------------------------------+------------------------------------
//  input   | in_valid, in_stall, in_data    | one item: received byte or tick
//  result  | out_valid, out_stall, out_data | one wrapped byte, trailer or abort
//  config  | cfg_we, cfg_index, cfg_wdata   | register write, no read-back
//
// the framer turns each item that is taken into a burst of zero to seven result items
// that the burst buffer hands out one per cycle while the result side does not stall
// the next item is taken in the same cycle as the final result item of the previous burst
// reset is synchronous, active low: framer goes idle, buffer empties, config returns to defaults
// a stall on the result side holds the buffer and, through in_stall, the input side

module serial_frame_encapsulator_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  sfe_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output sfe_pkg::out_item_t                  out_data,
  input  logic                                cfg_we,
  input  logic [sfe_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sfe_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  sfe_pkg::cfg_t   cfg_r, cfg_nxt;
  sfe_pkg::burst_t burst;
  logic            free;
  logic            accept;

  // config register file, writes beyond the list are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        sfe_pkg::CFG_PORT_NUMBER:   cfg_nxt.port_number   = cfg_wdata[7:0];
        sfe_pkg::CFG_LONG_ADDRESS:  cfg_nxt.long_address  = cfg_wdata[0];
        sfe_pkg::CFG_TIMEOUT_TICKS: cfg_nxt.timeout_ticks = cfg_wdata[15:0];
        default:                    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.port_number   <= '0;
      cfg_r.long_address  <= 1'b0;
      cfg_r.timeout_ticks <= sfe_pkg::TIMEOUT_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // input side is held off while the buffer is not free: more than its last item left, or that item stalled
  assign in_stall = !free;
  assign accept   = in_valid && free;

  sfe_framer u_framer (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .item   (in_data),
    .cfg    (cfg_r),
    .burst  (burst)
  );

  sfe_burst_buf u_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .burst     (burst),
    .free      (free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### dv/tb.sv
// self-checking testbench for serial_frame_encapsulator_unit: directed and random items
// with random idling on both channels, checked against an in-bench predictor
// depends on sfe_pkg and the rtl of serial_frame_encapsulator_unit
module tb;

  // cycles with no handshake on either channel before the run is declared hung
  localparam int WATCHDOG_LIMIT = 1000;
  // quiet cycles after the last wrapped byte before a register write
  localparam int SETTLE_CYCLES = 12;
  localparam int RANDOM_PHASES = 6;
  localparam int ITEMS_PER_PHASE = 20;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  sfe_pkg::in_item_t              in_data = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  sfe_pkg::out_item_t             out_data;
  logic                           cfg_we = 1'b0;
  logic [sfe_pkg::CFG_IDX_W-1:0]  cfg_index = sfe_pkg::CFG_PORT_NUMBER;
  logic [sfe_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  // register mirror, updated as each write is issued
  logic [7:0]  port_sel = 8'd0;
  logic        long_addr = 1'b0;
  logic [15:0] tick_limit = sfe_pkg::TIMEOUT_RESET;

  // framer mirror
  logic [8:0]  rx_count = '0;
  logic [8:0]  frame_len = '0;
  logic [7:0]  held_b0 = '0;
  logic [7:0]  held_b1 = '0;
  logic [7:0]  cksum = '0;
  logic [15:0] tick_count = '0;
  logic        in_fixed = 1'b0;

  sfe_pkg::in_item_t  pending_items[$];
  sfe_pkg::out_item_t wrapped_q[$];

  int in_gap_max = 14;
  int out_gap_max = 14;
  int in_wait = 0;
  int out_hold = 0;
  bit in_fired = 1'b0;
  bit out_fired = 1'b0;
  int quiet_cycles = 0;
  int err_cnt = 0;

  serial_frame_encapsulator_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  task automatic expect_byte(input logic [7:0] b, input logic lst, input logic ab);
    sfe_pkg::out_item_t e;
    e.tx_byte = b;
    e.last    = lst;
    e.abort   = ab;
    wrapped_q.push_back(e);
  endtask

  task automatic clear_frame();
    rx_count   = '0;
    frame_len  = '0;
    held_b0    = '0;
    held_b1    = '0;
    cksum      = '0;
    tick_count = '0;
    in_fixed   = 1'b0;
  endtask

  // sync, length low, length high, port; checksum starts from the last three
  task automatic emit_header();
    logic [7:0] lo;
    logic [7:0] hi;
    lo = frame_len[7:0];
    hi = {7'd0, frame_len[8]};
    expect_byte(sfe_pkg::HDR_SYNC, 1'b0, 1'b0);
    expect_byte(lo, 1'b0, 1'b0);
    expect_byte(hi, 1'b0, 1'b0);
    expect_byte(port_sel, 1'b0, 1'b0);
    cksum = lo + hi + port_sel;
  endtask

  task automatic emit_frame_byte(input logic [7:0] b);
    expect_byte(b, 1'b0, 1'b0);
    cksum = cksum + b;
  endtask

  // checksum and trailer once the whole frame has been seen
  task automatic close_frame();
    if (rx_count >= frame_len) begin
      expect_byte(cksum, 1'b0, 1'b0);
      expect_byte(sfe_pkg::TRAILER, 1'b1, 1'b0);
      clear_frame();
    end
  endtask

  task automatic predict_wrapped(input sfe_pkg::in_item_t it);
    logic [7:0] b;
    logic [7:0] m;
    b = it.rx_byte;
    if (it.op == sfe_pkg::OP_TICK) begin
      // ticks only count inside a frame; the counter saturates
      if (rx_count != 9'd0) begin
        if (tick_count != 16'hFFFF) tick_count = tick_count + 16'd1;
        if (tick_count >= tick_limit) begin
          expect_byte(8'h00, 1'b1, 1'b1);
          clear_frame();
        end
      end
    end else if (rx_count == 9'd0) begin
      tick_count = '0;
      rx_count   = 9'd1;
      if (b == sfe_pkg::FIXED_START) begin
        // fixed frame: length known at once, header goes out straight away
        in_fixed  = 1'b1;
        frame_len = long_addr ? sfe_pkg::FIXED_LEN_LONG : sfe_pkg::FIXED_LEN_SHORT;
        emit_header();
        emit_frame_byte(b);
        close_frame();
      end else begin
        in_fixed = 1'b0;
        held_b0  = b;
      end
    end else if (!in_fixed && rx_count == 9'd1) begin
      held_b1  = b;
      rx_count = 9'd2;
    end else if (!in_fixed && rx_count == 9'd2) begin
      // variable frame: unsigned minimum of bytes one and two, plus six
      m = (held_b1 < b) ? held_b1 : b;
      frame_len = {1'b0, m} + sfe_pkg::VAR_LEN_OFFSET;
      rx_count  = 9'd3;
      emit_header();
      emit_frame_byte(held_b0);
      emit_frame_byte(held_b1);
      emit_frame_byte(b);
      close_frame();
    end else begin
      rx_count = rx_count + 9'd1;
      emit_frame_byte(b);
      close_frame();
    end
  endtask

  // ---------------------------------------------------------------------------
  // monitor, scoreboard and watchdog, all sampled at the rising edge
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    sfe_pkg::out_item_t want;
    in_fired  = 1'b0;
    out_fired = 1'b0;
    if (rst_n) begin
      in_fired  = in_valid && !in_stall;
      out_fired = out_valid && !out_stall;
      // check before predicting: a new item never yields a result at its own edge
      if (out_fired) begin
        if (wrapped_q.size() == 0) begin
          $error("result item with nothing expected: tx_byte %02h last %0b abort %0b",
                 out_data.tx_byte, out_data.last, out_data.abort);
          err_cnt++;
        end else begin
          want = wrapped_q.pop_front();
          if (out_data.tx_byte !== want.tx_byte) begin
            $error("tx_byte mismatch: expected %02h, actual %02h",
                   want.tx_byte, out_data.tx_byte);
            err_cnt++;
          end
          if (out_data.last !== want.last) begin
            $error("last mismatch: expected %0b, actual %0b", want.last, out_data.last);
            err_cnt++;
          end
          if (out_data.abort !== want.abort) begin
            $error("abort mismatch: expected %0b, actual %0b", want.abort, out_data.abort);
            err_cnt++;
          end
        end
      end
      if (in_fired) predict_wrapped(in_data);
      if (in_fired || out_fired) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL serial_frame_encapsulator_unit");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // driver: one item at a time from the pending queue, changed at the falling edge
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    if (!in_valid || in_fired) begin
      if (in_wait > 0) begin
        in_wait--;
        in_valid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        in_data  <= pending_items.pop_front();
        in_valid <= 1'b1;
        // idle cycles to leave once this item has gone in
        in_wait = $urandom_range(0, in_gap_max);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: after each result item, stall for a freshly drawn number of cycles
  always @(negedge clk) begin
    if (out_fired) out_hold = $urandom_range(0, out_gap_max);
    if (out_hold > 0) begin
      out_stall <= 1'b1;
      out_hold--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic void queue_byte(input logic [7:0] b);
    sfe_pkg::in_item_t it;
    it.op      = sfe_pkg::OP_BYTE;
    it.rx_byte = b;
    pending_items.push_back(it);
  endfunction

  // rx_byte is ignored on a tick, so it carries noise
  function automatic void queue_tick();
    sfe_pkg::in_item_t it;
    it.op      = sfe_pkg::OP_TICK;
    it.rx_byte = 8'($urandom_range(0, 255));
    pending_items.push_back(it);
  endfunction

  // a frame byte, now and then preceded by a tick or two
  function automatic int queue_frame_byte(input logic [7:0] b);
    int n;
    n = 1;
    if ($urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 2)) begin
        queue_tick();
        n++;
      end
    end
    queue_byte(b);
    return n;
  endfunction

  // fixed frame, mostly of the length that long_address selects, sometimes of a random length from one to six
  function automatic int queue_fixed_frame();
    int len;
    int n;
    len = long_addr ? 6 : 5;
    if ($urandom_range(0, 4) == 0) len = $urandom_range(1, 6);
    queue_byte(sfe_pkg::FIXED_START);
    n = 1;
    for (int i = 1; i < len; i++) n += queue_frame_byte(8'($urandom_range(0, 255)));
    return n;
  endfunction

  // variable frame whose length field minimum is m
  function automatic int queue_var_frame(input int m);
    logic [7:0] first;
    logic [7:0] other;
    int n;
    do first = 8'($urandom_range(0, 255)); while (first == sfe_pkg::FIXED_START);
    other = 8'($urandom_range(m, 255));
    queue_byte(first);
    n = 1;
    if ($urandom_range(0, 1) == 1) begin
      n += queue_frame_byte(8'(m));
      n += queue_frame_byte(other);
    end else begin
      n += queue_frame_byte(other);
      n += queue_frame_byte(8'(m));
    end
    for (int i = 0; i < m + 3; i++) n += queue_frame_byte(8'($urandom_range(0, 255)));
    return n;
  endfunction

  task automatic write_reg(input logic [sfe_pkg::CFG_IDX_W-1:0] idx,
                           input logic [15:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      sfe_pkg::CFG_PORT_NUMBER:   port_sel   = val[7:0];
      sfe_pkg::CFG_LONG_ADDRESS:  long_addr  = val[0];
      sfe_pkg::CFG_TIMEOUT_TICKS: tick_limit = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // wait for every item to go in and every wrapped byte to come out, then let
  // the block finish anything that produces no result
  task automatic settle();
    wait (pending_items.size() == 0 && !in_valid && wrapped_q.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // close a frame left open with a one-tick timeout and a single tick
  task automatic finish_open_frame();
    if (rx_count != 9'd0) begin
      write_reg(sfe_pkg::CFG_TIMEOUT_TICKS, 16'd1);
      queue_tick();
      settle();
    end
  endtask

  task automatic run_random_phase();
    int made;
    int kind;
    int m;
    made = 0;
    while (made < ITEMS_PER_PHASE) begin
      kind = $urandom_range(0, 9);
      if (kind < 3) begin
        made += queue_fixed_frame();
      end else if (kind < 7) begin
        m = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
        made += queue_var_frame(m);
      end else if (kind < 8) begin
        // stray ticks, idle or mid-frame depending on what came before
        repeat ($urandom_range(1, 3)) begin
          queue_tick();
          made++;
        end
      end else begin
        // loose bytes that break up the framing
        repeat ($urandom_range(1, 3)) begin
          queue_byte(8'($urandom_range(0, 255)));
          made++;
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------

  initial begin
    logic [15:0] tmo;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // port zero, short fixed frames, longest timeout so ticks never abort
    write_reg(sfe_pkg::CFG_PORT_NUMBER, 16'd0);
    write_reg(sfe_pkg::CFG_LONG_ADDRESS, 16'd0);
    write_reg(sfe_pkg::CFG_TIMEOUT_TICKS, 16'hFFFF);
    queue_tick();                                    // tick while idle: nothing comes out
    queue_byte(sfe_pkg::FIXED_START);                // 5-byte fixed frame, tick inside
    queue_tick();
    queue_byte(8'h00);
    queue_byte(8'hFF);
    queue_byte(8'h01);
    queue_byte(8'h80);
    queue_byte(8'h01);                               // variable frame: 0x80 vs 0x00 is
    queue_byte(8'h80);                               // an unsigned compare, length 6
    queue_byte(8'h00);
    queue_tick();
    queue_byte(8'h7F);
    queue_byte(8'hFE);
    queue_byte(sfe_pkg::FIXED_START);                // start value inside a frame is data
    settle();

    // highest port, long fixed frames, shortest timeout
    write_reg(sfe_pkg::CFG_PORT_NUMBER, 16'h00FF);
    write_reg(sfe_pkg::CFG_LONG_ADDRESS, 16'd1);
    write_reg(sfe_pkg::CFG_TIMEOUT_TICKS, 16'd1);
    queue_byte(sfe_pkg::FIXED_START);                // 6-byte fixed frame
    queue_byte(8'h55);
    queue_byte(8'hAA);
    queue_byte(8'h00);
    queue_byte(8'hFF);
    queue_byte(8'h01);
    queue_byte(8'h7F);                               // abort before any header went out
    queue_tick();
    queue_byte(8'hFF);                               // length 261 header, then abort
    queue_byte(8'hFF);
    queue_byte(8'hFF);
    queue_tick();
    settle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case ($urandom_range(0, 3))
        0:       tmo = 16'd1;
        1:       tmo = 16'($urandom_range(2, 12));
        2:       tmo = 16'($urandom_range(13, 65534));
        default: tmo = 16'hFFFF;
      endcase
      write_reg(sfe_pkg::CFG_PORT_NUMBER, 16'($urandom_range(0, 255)));
      write_reg(sfe_pkg::CFG_LONG_ADDRESS, 16'($urandom_range(0, 1)));
      write_reg(sfe_pkg::CFG_TIMEOUT_TICKS, tmo);
      // first phase runs flat out, the others idle at random on either side
      in_gap_max  = (p == 0 || $urandom_range(0, 2) == 0) ? 0 : 14;
      out_gap_max = (p == 0 || $urandom_range(0, 2) == 0) ? 0 : 14;
      run_random_phase();
      settle();
      finish_open_frame();
    end

    if (err_cnt == 0) begin
      $display("PASS serial_frame_encapsulator_unit");
    end else begin
      $display("FAIL serial_frame_encapsulator_unit");
    end
    $finish;
  end

endmodule
